// File: rtl/core/ssmeg_pkg.sv
package ssmeg_pkg;

    // Field widths fixed by the item formats
    localparam int ROW_W      = 10;
    localparam int IDX_W      = 20;
    localparam int VAL_W      = 32;
    localparam int CIDX_W     = 5;
    localparam int DIM_CFG_W  = 11;
    localparam int SIZE_CFG_W = 3;
    localparam int THR_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [VAL_W-1:0] RESET_SCALE = 32'sd65536;
    localparam logic [THR_W-1:0]        RESET_THR   = '0;

    typedef enum logic [0:0] {
        FUNC_LOAD  = 1'b0,
        FUNC_POINT = 1'b1
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS      = 3'd0,
        CFG_GRID_COLS      = 3'd1,
        CFG_STENCIL_SIZE   = 3'd2,
        CFG_KINETIC_SCALE  = 3'd3,
        CFG_COEF_THRESHOLD = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        func_t                   func;
        logic [ROW_W-1:0]        point_row;
        logic [ROW_W-1:0]        point_col;
        logic [CIDX_W-1:0]       coef_index;
        logic signed [VAL_W-1:0] coef_value;
        logic signed [VAL_W-1:0] potential;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]        entry_row;
        logic [IDX_W-1:0]        entry_col;
        logic signed [VAL_W-1:0] entry_value;
        logic                    last;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic setup;
        logic scan;
        logic flush;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_grid;
        logic scan_end;
        logic adv;
        logic flush_done;
    } sts_t;

endpackage

// File: rtl/core/ssmeg_ram.sv
module ssmeg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ssmeg_ctrl.sv
module ssmeg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  ssmeg_pkg::func_t   req_func,
    input  ssmeg_pkg::sts_t    sts,
    output logic               req_stall,
    output ssmeg_pkg::cmd_t    cmd
);

    ssmeg_pkg::state_t state_reg;
    ssmeg_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssmeg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssmeg_pkg::ST_IDLE:
            begin
                if (req_valid && req_func == ssmeg_pkg::FUNC_POINT && sts.in_grid)
                begin
                    state_next = ssmeg_pkg::ST_SETUP;
                end
            end
            ssmeg_pkg::ST_SETUP:
            begin
                state_next = ssmeg_pkg::ST_SCAN;
            end
            ssmeg_pkg::ST_SCAN:
            begin
                if (sts.adv && sts.scan_end)
                begin
                    state_next = ssmeg_pkg::ST_DRAIN;
                end
            end
            ssmeg_pkg::ST_DRAIN:
            begin
                if (sts.flush_done)
                begin
                    state_next = ssmeg_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ssmeg_pkg::ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            ssmeg_pkg::ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ssmeg_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ssmeg_pkg::ST_DRAIN:
            begin
                cmd.flush = 1'b1;
            end
        endcase
    end

    // setup always moves on to scan
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ssmeg_pkg::ST_SETUP |=> state_reg == ssmeg_pkg::ST_SCAN)
        else $error("setup did not move to scan");

    // a frozen pipeline holds the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssmeg_pkg::ST_SCAN && !sts.adv) |=> state_reg == ssmeg_pkg::ST_SCAN)
        else $error("scan left while pipeline frozen");

endmodule

// File: rtl/core/ssmeg_dp.sv
module ssmeg_dp #(
    parameter int MAX_STENCIL = 5,
    parameter int MAX_DIM     = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ssmeg_pkg::cmd_t                       cmd,
    input  ssmeg_pkg::req_t                       req,
    input  logic                                  cfg_we,
    input  logic [ssmeg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssmeg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  rsp_stall,
    output ssmeg_pkg::sts_t                       sts,
    output logic                                  rsp_valid,
    output ssmeg_pkg::rsp_t                       rsp
);

    localparam int DEPTH = MAX_STENCIL * MAX_STENCIL;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int HW    = $clog2(MAX_STENCIL / 2 + 2);
    localparam int EW    = HW + 1;
    localparam int CW    = ((DW > ssmeg_pkg::ROW_W) ? DW : ssmeg_pkg::ROW_W) + 2;
    localparam int FW    = 2 * DW + 1;
    localparam int SFW   = ssmeg_pkg::ROW_W + DW + 1;
    localparam int SZW   = ssmeg_pkg::SIZE_CFG_W;
    localparam int RESET_DIM  = (MAX_DIM < 16) ? MAX_DIM : 16;
    localparam int RESET_SIZE = (MAX_STENCIL < 3) ? MAX_STENCIL : 3;
    localparam int RESET_H    = (RESET_SIZE - 1) / 2;

    // ---------------- configuration ----------------
    logic [DW-1:0]               rows_reg;
    logic [DW-1:0]               cols_reg;
    logic [HW-1:0]               h_reg;
    logic signed [31:0]          ks_reg;
    logic [ssmeg_pkg::THR_W-1:0] thr_reg;

    logic [ssmeg_pkg::DIM_CFG_W-1:0] cfg_dim;
    logic [DW-1:0]                   dim_clamped;
    logic [SZW-1:0]                  size_eff;
    logic [HW-1:0]                   h_new;

    always_comb
    begin
        cfg_dim = cfg_data[ssmeg_pkg::DIM_CFG_W-1:0];
        if (cfg_dim == '0)
        begin
            dim_clamped = DW'(1);
        end
        else if (int'(cfg_dim) > MAX_DIM)
        begin
            dim_clamped = DW'(MAX_DIM);
        end
        else
        begin
            dim_clamped = DW'(cfg_dim);
        end

        if (int'(cfg_data[SZW-1:0]) > MAX_STENCIL)
        begin
            size_eff = SZW'(MAX_STENCIL);
        end
        else
        begin
            size_eff = cfg_data[SZW-1:0];
        end
        // even sizes round down, zero acts as one
        h_new = (size_eff == '0) ? '0 : HW'((size_eff - SZW'(1)) >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DW'(RESET_DIM);
            cols_reg <= DW'(RESET_DIM);
            h_reg    <= HW'(RESET_H);
            ks_reg   <= ssmeg_pkg::RESET_SCALE;
            thr_reg  <= ssmeg_pkg::RESET_THR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssmeg_pkg::CFG_GRID_ROWS:      rows_reg <= dim_clamped;
                ssmeg_pkg::CFG_GRID_COLS:      cols_reg <= dim_clamped;
                ssmeg_pkg::CFG_STENCIL_SIZE:   h_reg    <= h_new;
                ssmeg_pkg::CFG_KINETIC_SCALE:  ks_reg   <= $signed(cfg_data);
                ssmeg_pkg::CFG_COEF_THRESHOLD: thr_reg  <= cfg_data[ssmeg_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- point capture ----------------
    logic [ssmeg_pkg::ROW_W-1:0] row_reg;
    logic [ssmeg_pkg::ROW_W-1:0] col_reg;
    logic signed [31:0]          pot_reg;
    logic [ssmeg_pkg::IDX_W-1:0] self_reg;
    logic [SFW-1:0]              self_full;

    assign self_full = SFW'(row_reg) * SFW'(cols_reg) + SFW'(col_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture && req.func == ssmeg_pkg::FUNC_POINT)
        begin
            row_reg <= req.point_row;
            col_reg <= req.point_col;
            pot_reg <= req.potential;
        end
        if (cmd.setup)
        begin
            self_reg <= ssmeg_pkg::IDX_W'(self_full);
        end
    end

    assign sts.in_grid = (CW'(req.point_row) < CW'(rows_reg))
                      && (CW'(req.point_col) < CW'(cols_reg));

    // ---------------- coefficient table ----------------
    logic          tbl_we;
    logic          tbl_re;
    logic [31:0]   tbl_rdata;
    logic [AW-1:0] tidx_reg;
    logic          adv;

    assign tbl_we = cmd.capture && req.func == ssmeg_pkg::FUNC_LOAD
                 && (int'(req.coef_index) < DEPTH);
    assign tbl_re = adv && cmd.scan;

    ssmeg_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (AW'(req.coef_index)),
        .wr_data (req.coef_value),
        .rd_en   (tbl_re),
        .rd_addr (tidx_reg),
        .rd_data (tbl_rdata)
    );

    // ---------------- offset scan ----------------
    logic [EW-1:0] dxi_reg;
    logic [EW-1:0] dyi_reg;
    logic [EW-1:0] edge_m1;
    logic [CW-1:0] h_ext;
    logic [CW-1:0] rsum_x;
    logic [CW-1:0] csum_y;
    logic          row_ok;
    logic          col_ok;
    logic          scan_diag;

    assign edge_m1   = {h_reg, 1'b0};
    assign h_ext     = CW'(h_reg);
    assign rsum_x    = CW'(row_reg) + CW'(dxi_reg);
    assign csum_y    = CW'(col_reg) + CW'(dyi_reg);
    assign row_ok    = (rsum_x >= h_ext) && (rsum_x < CW'(rows_reg) + h_ext);
    assign col_ok    = (csum_y >= h_ext) && (csum_y < CW'(cols_reg) + h_ext);
    assign scan_diag = (dxi_reg == EW'(h_reg)) && (dyi_reg == EW'(h_reg));
    assign sts.scan_end = (dxi_reg == edge_m1) && (dyi_reg == edge_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dxi_reg  <= '0;
            dyi_reg  <= '0;
            tidx_reg <= '0;
        end
        else if (cmd.setup)
        begin
            dxi_reg  <= '0;
            dyi_reg  <= '0;
            tidx_reg <= '0;
        end
        else if (cmd.scan && adv)
        begin
            tidx_reg <= tidx_reg + AW'(1);
            if (dyi_reg == edge_m1)
            begin
                dyi_reg <= '0;
                dxi_reg <= dxi_reg + EW'(1);
            end
            else
            begin
                dyi_reg <= dyi_reg + EW'(1);
            end
        end
    end

    // ---------------- pipeline ----------------
    logic          s1_valid_reg;
    logic [DW-1:0] s1_r_reg;
    logic [DW-1:0] s1_c_reg;
    logic          s1_diag_reg;

    logic signed [31:0] coef;
    logic [31:0]        mag;
    logic               pass;

    logic               s2_valid_reg;
    logic signed [31:0] s2_coef_reg;
    logic [DW-1:0]      s2_r_reg;
    logic [DW-1:0]      s2_c_reg;
    logic               s2_diag_reg;

    logic signed [63:0] prod;
    logic [FW-1:0]      fcol_full;

    logic                        s3_valid_reg;
    logic signed [63:0]          s3_prod_reg;
    logic [ssmeg_pkg::IDX_W-1:0] s3_fcol_reg;
    logic                        s3_diag_reg;

    assign coef = $signed(tbl_rdata);
    assign mag  = coef[31] ? (~tbl_rdata + 32'd1) : tbl_rdata;
    assign pass = mag > {1'b0, thr_reg};

    assign prod      = s2_coef_reg * ks_reg;
    assign fcol_full = FW'(s2_r_reg) * FW'(cols_reg) + FW'(s2_c_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= cmd.scan && row_ok && col_ok;
            s2_valid_reg <= s1_valid_reg && (pass || s1_diag_reg);
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_r_reg    <= DW'(rsum_x - h_ext);
            s1_c_reg    <= DW'(csum_y - h_ext);
            s1_diag_reg <= scan_diag;
            s2_coef_reg <= pass ? coef : 32'sd0;
            s2_r_reg    <= s1_r_reg;
            s2_c_reg    <= s1_c_reg;
            s2_diag_reg <= s1_diag_reg;
            s3_prod_reg <= prod;
            s3_fcol_reg <= ssmeg_pkg::IDX_W'(fcol_full);
            s3_diag_reg <= s2_diag_reg;
        end
    end

    // round half up, potential folded in above the fraction bits
    logic [64:0]        rbias;
    logic signed [64:0] rsum;
    logic signed [48:0] rval;
    logic signed [31:0] sat_val;

    always_comb
    begin
        rbias = s3_diag_reg ? {{17{pot_reg[31]}}, pot_reg, 16'h8000} : 65'h8000;
        rsum  = {s3_prod_reg[63], s3_prod_reg} + $signed(rbias);
        rval  = rsum[64:16];
        if (!rval[48] && (|rval[47:31]))
        begin
            sat_val = 32'sh7FFF_FFFF;
        end
        else if (rval[48] && !(&rval[47:31]))
        begin
            sat_val = 32'sh8000_0000;
        end
        else
        begin
            sat_val = rval[31:0];
        end
    end

    // ---------------- pending entry and output register ----------------
    // one entry is held back so the final one can be marked last
    logic                        pend_valid_reg;
    logic [ssmeg_pkg::IDX_W-1:0] pend_col_reg;
    logic signed [31:0]          pend_val_reg;
    logic                        out_valid_reg;
    ssmeg_pkg::rsp_t             out_reg;
    logic                        out_free;
    logic                        push;
    logic                        flush_fire;
    logic                        move;

    assign out_free   = !out_valid_reg || !rsp_stall;
    assign adv        = !(s3_valid_reg && pend_valid_reg && !out_free);
    assign push       = adv && s3_valid_reg;
    assign flush_fire = cmd.flush && pend_valid_reg && out_free
                     && !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;
    assign move       = (push && pend_valid_reg) || flush_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush_fire)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            pend_col_reg <= s3_fcol_reg;
            pend_val_reg <= sat_val;
        end
        if (move)
        begin
            out_reg.entry_row   <= self_reg;
            out_reg.entry_col   <= pend_col_reg;
            out_reg.entry_value <= pend_val_reg;
            out_reg.last        <= flush_fire;
        end
    end

    assign sts.adv        = adv;
    assign sts.flush_done = flush_fire;
    assign rsp_valid      = out_valid_reg;
    assign rsp            = out_reg;

    // pending only spills into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && pend_valid_reg) |-> out_free)
        else $error("pending entry overwrote a held result");

    // a new point starts on an empty pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.setup |-> (!pend_valid_reg && !s1_valid_reg && !s2_valid_reg && !s3_valid_reg))
        else $error("pipeline not empty at point setup");

    // a freeze keeps both the last stage and the pending entry
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> (s3_valid_reg && pend_valid_reg))
        else $error("entry lost during pipeline freeze");

endmodule

// File: rtl/core/stencil_sparse_matrix_entry_generator.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------
// req      | in        | req_valid / req_stall  | ssmeg_pkg::req_t (load or point)
// rsp      | out       | rsp_valid / rsp_stall  | ssmeg_pkg::rsp_t (one entry)
// cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A load item or a point outside the grid is taken without leaving idle.
// A point inside the grid goes through accept, setup, one offset per cycle while
// the pipeline is not frozen (e*e offsets, e the effective stencil edge) through
// the single read port of the coefficient RAM, three stages behind the read
// (coefficient check, multiply, round into the pending slot), then the flush.
// Reset clears control and sets configuration to its defaults; coefficients
// are undefined until loaded, no clearing pass. A stalled rsp freezes the
// pipeline once the last stage and the pending slot are both full; one result
// waits in the output register while the next sits in the pending slot.
module stencil_sparse_matrix_entry_generator #(
    parameter int MAX_STENCIL = 5,
    parameter int MAX_DIM     = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  ssmeg_pkg::req_t                      req,

    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output ssmeg_pkg::rsp_t                      rsp,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ssmeg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssmeg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ssmeg_pkg::cmd_t cmd;
    ssmeg_pkg::sts_t sts;

    // registers are plain flops, always writable
    assign cfg_ready = 1'b1;

    // controller: sequences capture, setup, offset scan and final flush
    ssmeg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_func  (req.func),
        .sts       (sts),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    // datapath: config, coefficient RAM, scan counters, multiply and
    // rounding pipeline, pending slot and output register
    ssmeg_dp #(
        .MAX_STENCIL (MAX_STENCIL),
        .MAX_DIM     (MAX_DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ssmeg_pkg::*;

    localparam int MAX_STENCIL  = 5;
    localparam int MAX_DIM      = 1024;
    localparam int TABLE_DEPTH  = MAX_STENCIL * MAX_STENCIL;
    // worst point's offsets, setup, pipeline and flush, plus margin
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 15;
    localparam int HOLD_CYCLES  = 150;
    // no handshake on any channel for this long means the block is stuck
    localparam int QUIET_LIMIT  = 2000;

    // Tracks register and coefficient state as the block sees it and keeps
    // the queue of sparse matrix entries still owed by the block.
    class entry_scoreboard;
        logic [DIM_CFG_W-1:0]    rows_cfg;
        logic [DIM_CFG_W-1:0]    cols_cfg;
        logic [SIZE_CFG_W-1:0]   size_cfg;
        logic signed [VAL_W-1:0] scale_cfg;
        logic [THR_W-1:0]        thr_cfg;
        logic signed [VAL_W-1:0] coef_table [TABLE_DEPTH];
        rsp_t                    owed_entries [$];
        int                      errors;
        int                      loads_seen;
        int                      points_seen;
        int                      entries_checked;

        function new();
            rows_cfg  = 16;
            cols_cfg  = 16;
            size_cfg  = 3;
            scale_cfg = RESET_SCALE;
            thr_cfg   = RESET_THR;
            foreach (coef_table[i])
                coef_table[i] = '0;
        endfunction

        function longint clamp_dim(logic [DIM_CFG_W-1:0] d);
            if (d == 0)
                return 1;
            if (d > MAX_DIM)
                return MAX_DIM;
            return longint'(d);
        endfunction

        // even sizes round down to the next odd one, zero acts as one
        function int edge_len(logic [SIZE_CFG_W-1:0] s);
            int s_cap;
            int h;
            s_cap = (s < MAX_STENCIL) ? int'(s) : MAX_STENCIL;
            h = (s_cap >= 1) ? (s_cap - 1) / 2 : 0;
            return 2 * h + 1;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GRID_ROWS:      rows_cfg  = data[DIM_CFG_W-1:0];
                CFG_GRID_COLS:      cols_cfg  = data[DIM_CFG_W-1:0];
                CFG_STENCIL_SIZE:   size_cfg  = data[SIZE_CFG_W-1:0];
                CFG_KINETIC_SCALE:  scale_cfg = data;
                CFG_COEF_THRESHOLD: thr_cfg   = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(req_t it);
            longint rows, cols, row, col, h, e, dx, dy, r, c;
            longint coef, mag, val, self_idx, nbr_idx;
            bit     passes, diag, have_held;
            rsp_t   held, ent;
            have_held = 1'b0;
            held = '0;
            if (it.func == FUNC_LOAD)
            begin
                loads_seen++;
                if (it.coef_index < TABLE_DEPTH)
                    coef_table[it.coef_index] = it.coef_value;
                return;
            end
            points_seen++;
            rows = clamp_dim(rows_cfg);
            cols = clamp_dim(cols_cfg);
            row  = longint'(it.point_row);
            col  = longint'(it.point_col);
            if (row >= rows || col >= cols)
                return;
            e = edge_len(size_cfg);
            h = (e - 1) / 2;
            self_idx = row * cols + col;
            for (dx = -h; dx <= h; dx++)
            begin
                r = row + dx;
                if (r < 0 || r >= rows)
                    continue;
                for (dy = -h; dy <= h; dy++)
                begin
                    c = col + dy;
                    if (c < 0 || c >= cols)
                        continue;
                    coef   = longint'(coef_table[(dx + h) * e + (dy + h)]);
                    mag    = (coef < 0) ? -coef : coef;
                    passes = mag > longint'(thr_cfg);
                    diag   = (dx == 0) && (dy == 0);
                    if (!passes && !diag)
                        continue;
                    // round half up: floor((p + 0.5 lsb) / 2^16)
                    val = passes ? ((coef * longint'(scale_cfg) + 64'sd32768) >>> 16) : 0;
                    if (diag)
                        val += longint'(it.potential);
                    if (val > 64'sd2147483647)
                        val = 64'sd2147483647;
                    else if (val < -64'sd2147483648)
                        val = -64'sd2147483648;
                    nbr_idx = r * cols + c;
                    ent.entry_row   = self_idx[IDX_W-1:0];
                    ent.entry_col   = nbr_idx[IDX_W-1:0];
                    ent.entry_value = val[VAL_W-1:0];
                    ent.last        = 1'b0;
                    // hold one back so the final entry can carry last
                    if (have_held)
                        owed_entries.push_back(held);
                    held = ent;
                    have_held = 1'b1;
                end
            end
            if (have_held)
            begin
                held.last = 1'b1;
                owed_entries.push_back(held);
            end
        endfunction

        function void check_entry(rsp_t got);
            rsp_t want;
            if (owed_entries.size() == 0)
            begin
                $error("unexpected entry: row %0d col %0d value %0d",
                       got.entry_row, got.entry_col, $signed(got.entry_value));
                errors++;
                return;
            end
            want = owed_entries.pop_front();
            entries_checked++;
            if (got.entry_row !== want.entry_row)
            begin
                $error("entry_row: expected %0d, actual %0d", want.entry_row, got.entry_row);
                errors++;
            end
            if (got.entry_col !== want.entry_col)
            begin
                $error("entry_col: expected %0d, actual %0d", want.entry_col, got.entry_col);
                errors++;
            end
            if (got.entry_value !== want.entry_value)
            begin
                $error("entry_value: expected %0d, actual %0d",
                       $signed(want.entry_value), $signed(got.entry_value));
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction

        function void report_leftover();
            if (owed_entries.size() != 0)
            begin
                $error("%0d expected entries never came out", owed_entries.size());
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_t                  rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    entry_scoreboard book;

    // stimulus-side copy of the register settings, used to shape items
    logic [DIM_CFG_W-1:0]  cur_rows = 16;
    logic [DIM_CFG_W-1:0]  cur_cols = 16;
    logic [SIZE_CFG_W-1:0] cur_size = 3;
    // coefficients already sent; a point never reads an unloaded one
    bit                    coef_loaded [TABLE_DEPTH];

    bit src_idle_en;
    bit sink_idle_en;
    bit hold_request;
    int quiet_cycles;
    int long_holds;
    int drain_pauses;
    int settings_used;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    stencil_sparse_matrix_entry_generator #(
        .MAX_STENCIL (MAX_STENCIL),
        .MAX_DIM     (MAX_DIM)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Monitor: all three channels are observed at the edge that completes the
    // handshake, so the predictor sees register writes, items and entries in
    // the order the block does.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                book.set_reg(cfg_reg_t'(cfg_index), cfg_data);
            if (req_valid && !req_stall)
                book.note_request(req);
            if (rsp_valid && !rsp_stall)
                book.check_entry(rsp);
        end
    end

    // Watchdog: counts cycles with no handshake anywhere.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Entry receiver. Random stall bursts while enabled; on request one long
    // hold-off so the block backs up into its input.
    initial
    begin
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
                long_holds++;
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Q16.16 values: extremes, zero, full random, and small magnitudes
    // (within +-2.0) so the threshold and rounding get exercised.
    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4:    return $urandom;
            default: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [DIM_CFG_W-1:0] rand_dim();
        if ($urandom_range(0, 9) == 0)
            return DIM_CFG_W'($urandom_range(0, 2047));
        return DIM_CFG_W'($urandom_range(1, 24));
    endfunction

    // unused fields carry random bits as well
    function automatic req_t load_item(input int idx, input logic [31:0] val);
        req_t it;
        it.func       = FUNC_LOAD;
        it.point_row  = ROW_W'($urandom);
        it.point_col  = ROW_W'($urandom);
        it.coef_index = CIDX_W'(idx);
        it.coef_value = val;
        it.potential  = $urandom;
        return it;
    endfunction

    function automatic req_t point_item(input logic [ROW_W-1:0] row,
                                        input logic [ROW_W-1:0] col,
                                        input logic [31:0] pot);
        req_t it;
        it.func       = FUNC_POINT;
        it.point_row  = row;
        it.point_col  = col;
        it.coef_index = CIDX_W'($urandom);
        it.coef_value = $urandom;
        it.potential  = pot;
        return it;
    endfunction

    // Holds the item until the edge where it is taken.
    task automatic send_item(input req_t it);
        req <= it;
        req_valid <= 1'b1;
        if (it.func == FUNC_LOAD && it.coef_index < TABLE_DEPTH)
            coef_loaded[it.coef_index] = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic feed_load(input int idx, input logic [31:0] val);
        send_item(load_item(idx, val));
        pause_sender();
    endtask

    // Loads any coefficient the current stencil could read first.
    task automatic feed_point(input logic [ROW_W-1:0] row, input logic [ROW_W-1:0] col,
                              input logic [31:0] pot);
        int span;
        span = book.edge_len(cur_size);
        for (int i = 0; i < span * span; i++)
            if (!coef_loaded[i])
                send_item(load_item(i, rand_q16()));
        send_item(point_item(row, col, pot));
        pause_sender();
    endtask

    // Sender quiet until every owed entry is out, then the block's own
    // latency in case it is still busy with an item that yields nothing.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (book.owed_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [DIM_CFG_W-1:0] r, input logic [DIM_CFG_W-1:0] c,
                                input logic [SIZE_CFG_W-1:0] s, input logic [31:0] k,
                                input logic [THR_W-1:0] t);
        cfg_reg_t              regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        regs = '{CFG_GRID_ROWS, CFG_GRID_COLS, CFG_STENCIL_SIZE,
                 CFG_KINETIC_SCALE, CFG_COEF_THRESHOLD};
        vals = '{CFG_DATA_W'(r), CFG_DATA_W'(c), CFG_DATA_W'(s), k, CFG_DATA_W'(t)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_rows = r;
        cur_cols = c;
        cur_size = s;
        settings_used++;
    endtask

    // Mostly points near or inside the grid, some loads, a few far-off points
    // and out-of-table load indexes.
    task automatic run_random(input int n);
        int         rows_top;
        int         cols_top;
        logic [9:0] r;
        logic [9:0] c;
        rows_top = int'(book.clamp_dim(cur_rows));
        cols_top = int'(book.clamp_dim(cur_cols));
        if (rows_top > 1023)
            rows_top = 1023;
        if (cols_top > 1023)
            cols_top = 1023;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 7) == 0)
                    feed_load($urandom_range(TABLE_DEPTH, 31), rand_q16());
                else
                    feed_load($urandom_range(0, TABLE_DEPTH - 1), rand_q16());
            end
            else
            begin
                r = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom)
                                                : ROW_W'($urandom_range(0, rows_top));
                c = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom)
                                                : ROW_W'($urandom_range(0, cols_top));
                feed_point(r, c, rand_q16());
            end
        end
    endtask

    task automatic run_phase(input logic [DIM_CFG_W-1:0] r, input logic [DIM_CFG_W-1:0] c,
                             input logic [SIZE_CFG_W-1:0] s, input logic [31:0] k,
                             input logic [THR_W-1:0] t, input int n,
                             input bit src_idle, input bit sink_idle);
        wait_drained();
        write_config(r, c, s, k, t);
        src_idle_en  = src_idle;
        sink_idle_en = sink_idle;
        run_random(n);
    endtask

    initial
    begin
        book = new();
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset settings: 16x16 grid, 3x3 stencil,
        // unit scale, zero threshold.
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        feed_load(0, 32'h7FFF_FFFF);
        feed_load(1, 32'h0);            // zero coefficient drops out off the diagonal
        feed_load(2, 32'h8000_0000);
        feed_load(3, 32'hFFFF_0000);
        feed_load(4, 32'h0);            // centre fails threshold: diagonal is potential only
        feed_load(5, 32'h0001_8000);
        feed_load(6, 32'h0000_0001);
        feed_load(7, 32'hFFFF_FFFF);
        feed_load(8, 32'h0000_8000);
        feed_load(31, 32'h1234_5678);   // past the table, ignored
        feed_load(TABLE_DEPTH, 32'hDEAD_BEEF);
        feed_point(10'd0, 10'd0, 32'h7FFF_FFFF);
        feed_point(10'd15, 10'd15, 32'h8000_0000);
        feed_point(10'd7, 10'd8, 32'h0);
        feed_point(10'd0, 10'd15, 32'h0001_0000);
        feed_point(10'd15, 10'd0, 32'hFFFF_8000);
        feed_point(10'd16, 10'd3, 32'h0001_0000);   // row outside grid
        feed_point(10'd3, 10'd16, 32'h0001_0000);   // column outside grid
        feed_point(10'd1023, 10'd1023, 32'hFFFF_FFFF);

        // Register sweeps: single-point grid, full grid,
        // out-of-range sizes that clamp, even and zero stencil sizes.
        run_phase(8, 12, 5, 32'h0001_0000, '0, 20, 1'b1, 1'b1);
        run_phase(1, 1, 3, 32'h7FFF_FFFF, '0, 15, 1'b1, 1'b0);
        run_phase(1024, 1024, 5, 32'h8000_0000, 31'h7FFF_FFFF, 20, 1'b0, 1'b1);
        run_phase(0, 2047, 0, $urandom, 31'h0000_8000, 15, 1'b0, 1'b0);
        run_phase(2047, 0, 7, 32'hFFFF_0000, 31'h0001_0000, 15, 1'b1, 1'b1);
        run_phase(6, 5, 4, 32'h0000_8000, 31'h0000_4000, 10, 1'b1, 1'b1);
        run_phase(5, 7, 2, 32'h0002_0000, '0, 10, 1'b1, 1'b1);

        // Backpressure: receiver holds off for a long stretch while points
        // keep coming, then the sender waits for a full drain mid-phase.
        wait_drained();
        write_config(20, 20, 5, rand_q16(), THR_W'($urandom_range(0, 32'h0001_0000)));
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_request = 1'b1;
        run_random(20);
        wait_drained();
        drain_pauses++;
        run_random(20);

        // Random settings; the last one runs with no idling on either side.
        for (int p = 0; p < 3; p++)
            run_phase(rand_dim(), rand_dim(), SIZE_CFG_W'($urandom_range(0, 7)), rand_q16(),
                      THR_W'($urandom_range(0, 32'h0002_0000)), 20, p < 2, p < 2);

        wait_drained();
        book.report_leftover();
        $display("covered %0d coefficient loads, %0d grid points, %0d entries checked",
                 book.loads_seen, book.points_seen, book.entries_checked);
        $display("over %0d register settings, %0d long output hold(s), %0d sender drain(s)",
                 settings_used + 1, long_holds, drain_pauses);
        if (book.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
